FILE: hdl/frp_pkg.sv
// frp_pkg: class codes and shared constants for float_round_and_pack.
// No dependencies.
package frp_pkg;
    localparam logic [2:0] CLS_QNAN = 3'd0;
    localparam logic [2:0] CLS_SNAN = 3'd1;
    localparam logic [2:0] CLS_ZERO = 3'd2;
    localparam logic [2:0] CLS_INF  = 3'd4;

    // result kind decided in stage one
    typedef enum logic [1:0] {
        K_NUM  = 2'd0,
        K_ZERO = 2'd1,
        K_INF  = 2'd2,
        K_NAN  = 2'd3
    } t_kind;

    // stage one to stage two
    typedef struct packed {
        logic        dbl;
        logic        sgn;
        t_kind       kind;
        logic        tiny;
        logic [6:0]  sh;       // shift amount, saturated at 64
        logic [11:0] biased;
        logic [63:0] f;
    } t_s1;

    // stage two to stage three
    typedef struct packed {
        logic        dbl;
        logic        sgn;
        t_kind       kind;
        logic [11:0] biased;
        logic [63:0] f;
    } t_s2;
endpackage

FILE: hdl/float_round_and_pack.sv
// float_round_and_pack: top level, three-stage round-and-pack pipeline.
// Uses frp_pkg, frp_classify, frp_denorm, frp_pack.
//
// Packs an unpacked float as IEEE binary32 (low 32 bits) or binary64, set by
// the precision register (reset 1 = binary64). Round to nearest even. One
// item per cycle sustained while the output is not stalled; three register
// stages (classify, denormalize and round, pack) lead to the output. A stall
// freezes a stage holding an item only while all later stages are full;
// empty stages still fill, so bubbles collapse. Write precision only while idle.
module float_round_and_pack (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_value_class,
    input  logic               i_sign_bit,
    input  logic signed [15:0] i_unbiased_exponent,
    input  logic [63:0]        i_mantissa_bits,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [63:0]        o_packed_word
);
    logic         r_prec;
    logic         r_v1, r_v2, r_v3;
    frp_pkg::t_s1 r_s1, n_s1;
    frp_pkg::t_s2 r_s2, n_s2;
    logic [63:0]  r_word, n_word;
    logic         adv3, adv2, adv1;

    // per-stage advance: a stage moves when its successor can take it
    assign adv3 = !r_v3 || !i_stall;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign o_stall = !adv1;

    frp_classify u_cls (
        .i_dbl(r_prec), .i_value_class(i_value_class), .i_sign_bit(i_sign_bit),
        .i_unbiased_exponent(i_unbiased_exponent), .i_mantissa_bits(i_mantissa_bits),
        .o_s1(n_s1)
    );
    frp_denorm u_den (.i_s1(r_s1), .o_s2(n_s2));
    frp_pack   u_pck (.i_s2(r_s2), .o_word(n_word));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prec <= 1'b1;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
        end else begin
            if (i_cfg_we) r_prec <= i_cfg_wdata;
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (adv1) r_s1   <= n_s1;
        if (adv2) r_s2   <= n_s2;
        if (adv3) r_word <= n_word;
    end

    assign o_valid       = r_v3;
    assign o_packed_word = r_word;
endmodule

FILE: hdl/frp_classify.sv
// frp_classify: stage one, class decode, range checks, shift amount.
// Uses frp_pkg.
module frp_classify (
    input  logic               i_dbl,
    input  logic [2:0]         i_value_class,
    input  logic               i_sign_bit,
    input  logic signed [15:0] i_unbiased_exponent,
    input  logic [63:0]        i_mantissa_bits,
    output frp_pkg::t_s1       o_s1
);
    logic signed [17:0] e;
    logic signed [17:0] lo;
    logic signed [17:0] hi;
    logic signed [17:0] bias;
    logic signed [17:0] shf;
    logic signed [17:0] bsum;
    logic [63:0]        f;

    always_comb begin
        e    = 18'(i_unbiased_exponent);
        lo   = i_dbl ? -18'sd1022 : -18'sd126;
        hi   = i_dbl ? 18'sd1024 : 18'sd128;
        bias = i_dbl ? 18'sd1023 : 18'sd127;
        f    = i_dbl ? i_mantissa_bits : {32'd0, i_mantissa_bits[31:0]};
        shf  = lo - e;
        bsum = e + bias;
        o_s1.dbl    = i_dbl;
        o_s1.sgn    = i_sign_bit;
        o_s1.f      = f;
        o_s1.tiny   = (e < lo);
        o_s1.sh     = (shf > 18'sd64) ? 7'd64 : shf[6:0];
        o_s1.biased = (e < lo) ? 12'd0 : bsum[11:0];
        if (i_value_class == frp_pkg::CLS_QNAN || i_value_class == frp_pkg::CLS_SNAN)
            o_s1.kind = frp_pkg::K_NAN;
        else if (i_value_class == frp_pkg::CLS_ZERO)
            o_s1.kind = frp_pkg::K_ZERO;
        else if (i_value_class == frp_pkg::CLS_INF)
            o_s1.kind = frp_pkg::K_INF;
        else if (f == 64'd0)
            o_s1.kind = frp_pkg::K_ZERO;
        else if (e >= hi)
            o_s1.kind = frp_pkg::K_INF;
        else
            o_s1.kind = frp_pkg::K_NUM;
    end
endmodule

FILE: hdl/frp_denorm.sv
// frp_denorm: stage two, sticky right shift and round increment.
// Uses frp_pkg.
module frp_denorm (
    input  frp_pkg::t_s1 i_s1,
    output frp_pkg::t_s2 o_s2
);
    logic [63:0] f;
    logic [63:0] lost;
    logic [63:0] mask;
    logic        tie;

    always_comb begin
        f = i_s1.f;
        if (i_s1.tiny) begin
            if (i_s1.sh[6]) begin
                f = 64'd1;
            end else begin
                mask = (64'd1 << i_s1.sh[5:0]) - 64'd1;
                lost = i_s1.f & mask;
                f    = (i_s1.f >> i_s1.sh[5:0]) | {63'd0, lost != 64'd0};
            end
        end
        mask = 64'd0;
        lost = 64'd0;
        if (i_s1.dbl) begin
            tie = (f[7:0] == 8'h80) && f[8];
            f   = f + (tie ? 64'h80 : 64'h7f);
        end else begin
            tie = (f[6:0] == 7'h40) && f[7];
            f   = {32'd0, f[31:0] + (tie ? 32'h40 : 32'h3f)};
        end
        o_s2.dbl    = i_s1.dbl;
        o_s2.sgn    = i_s1.sgn;
        o_s2.kind   = i_s1.kind;
        o_s2.biased = i_s1.biased;
        // NaN payload passes through unshifted and unrounded
        o_s2.f      = (i_s1.kind == frp_pkg::K_NUM) ? f : i_s1.f;
    end
endmodule

FILE: hdl/frp_pack.sv
// frp_pack: stage three, carry fixup and field packing.
// Uses frp_pkg.
module frp_pack (
    input  frp_pkg::t_s2 i_s2,
    output logic [63:0]  o_word
);
    logic [63:0] f;
    logic [11:0] b;
    logic        carry;

    always_comb begin
        f     = i_s2.f;
        b     = i_s2.biased;
        carry = i_s2.dbl ? f[61] : f[31];
        if (carry) begin
            f = f >> 1;
            b = b + 12'd1;
        end
        if (b == 12'd0 && (i_s2.dbl ? f[60] : f[30]))
            b = 12'd1;
        o_word = 64'd0;
        if (i_s2.dbl) begin
            case (i_s2.kind)
                frp_pkg::K_ZERO: o_word = {i_s2.sgn, 63'd0};
                frp_pkg::K_INF:  o_word = {i_s2.sgn, 11'h7ff, 52'd0};
                frp_pkg::K_NAN:  o_word = {i_s2.sgn, 11'h7ff, 1'b1, i_s2.f[50:0]};
                default: begin
                    if (carry && b >= 12'h7ff)
                        o_word = {i_s2.sgn, 11'h7ff, 52'd0};
                    else
                        o_word = {i_s2.sgn, b[10:0], f[59:8]};
                end
            endcase
        end else begin
            case (i_s2.kind)
                frp_pkg::K_ZERO: o_word = {32'd0, i_s2.sgn, 31'd0};
                frp_pkg::K_INF:  o_word = {32'd0, i_s2.sgn, 8'hff, 23'd0};
                frp_pkg::K_NAN:  o_word = {32'd0, i_s2.sgn, 8'hff, i_s2.f[22:21],
                                           1'b1, i_s2.f[19:0]};
                default: begin
                    if (carry && b >= 12'h0ff)
                        o_word = {32'd0, i_s2.sgn, 8'hff, 23'd0};
                    else
                        o_word = {32'd0, i_s2.sgn, b[7:0], f[29:7]};
                end
            endcase
        end
    end
endmodule

FILE: test/testbench.sv
// testbench: checks float_round_and_pack against a built-in round-and-pack predictor.
// Depends on frp_pkg and float_round_and_pack.
`timescale 1ns / 1ps

module testbench;
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_wdata = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_value_class = '0;
    logic               i_sign_bit = 1'b0;
    logic signed [15:0] i_unbiased_exponent = '0;
    logic [63:0]        i_mantissa_bits = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [63:0]        o_packed_word;

    localparam logic [2:0] CLS_NUM = 3'd3;

    float_round_and_pack dut (.*);

    always #2 i_clk = ~i_clk;

    // model copy of the precision register
    logic        dbl_mode = 1'b1;
    logic [63:0] expected_words[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    // binary32 rounding and packing
    function automatic logic [31:0] pack32(logic s, int e, logic [31:0] f);
        logic [31:0] top;
        logic [31:0] b;
        int          sh;
        logic [31:0] lost;
        top = {s, 31'd0};
        if (f == 0) return top;
        if (e < -126) begin
            sh = -126 - e;
            if (sh >= 32) f = 32'd1;
            else begin
                lost = f & ((32'd1 << sh) - 32'd1);
                f = (f >> sh) | {31'd0, lost != 0};
            end
            b = 0;
        end else if (e >= 128) begin
            return top | 32'h7f800000;
        end else begin
            b = e + 127;
        end
        // ties to even: a tie with odd lsb rounds up
        if (f[6:0] == 7'h40 && f[7]) f = f + 32'h40;
        else f = f + 32'h3f;
        if (f[31]) begin
            f = f >> 1;
            b = b + 1;
            if (b >= 32'hff) return top | 32'h7f800000;
        end
        if (b == 0 && f[30]) b = 1;   // subnormal rounded into the hidden bit
        return top | ((b & 32'hff) << 23) | ((f >> 7) & 32'h007fffff);
    endfunction

    // binary64 rounding and packing
    function automatic logic [63:0] pack64(logic s, int e, logic [63:0] f);
        logic [63:0] top;
        logic [63:0] b;
        int          sh;
        logic [63:0] lost;
        top = {s, 63'd0};
        if (f == 0) return top;
        if (e < -1022) begin
            sh = -1022 - e;
            if (sh >= 64) f = 64'd1;
            else begin
                lost = f & ((64'd1 << sh) - 64'd1);
                f = (f >> sh) | {63'd0, lost != 0};
            end
            b = 0;
        end else if (e >= 1024) begin
            return top | 64'h7ff0000000000000;
        end else begin
            b = e + 1023;
        end
        if (f[7:0] == 8'h80 && f[8]) f = f + 64'h80;
        else f = f + 64'h7f;
        if (f[61]) begin
            f = f >> 1;
            b = b + 1;
            if (b >= 64'h7ff) return top | 64'h7ff0000000000000;
        end
        if (b == 0 && f[60]) b = 1;
        return top | ((b & 64'h7ff) << 52) | ((f >> 8) & 64'h000fffffffffffff);
    endfunction

    function automatic logic [63:0] predict_word(logic [2:0] c, logic s,
                                                 logic signed [15:0] e, logic [63:0] f);
        if (dbl_mode) begin
            if (c == frp_pkg::CLS_QNAN || c == frp_pkg::CLS_SNAN)
                return {s, 63'd0} | 64'h7ff0000000000000 |
                       ((f | 64'h0008000000000000) & 64'h000fffffffffffff);
            if (c == frp_pkg::CLS_ZERO) return {s, 63'd0};
            if (c == frp_pkg::CLS_INF) return {s, 63'd0} | 64'h7ff0000000000000;
            return pack64(s, int'(e), f);
        end
        if (c == frp_pkg::CLS_QNAN || c == frp_pkg::CLS_SNAN)
            return {32'd0, {s, 31'd0} | 32'h7f800000 |
                    ((f[31:0] | 32'h00100000) & 32'h007fffff)};
        if (c == frp_pkg::CLS_ZERO) return {32'd0, s, 31'd0};
        if (c == frp_pkg::CLS_INF) return {32'd0, {s, 31'd0} | 32'h7f800000};
        return {32'd0, pack32(s, int'(e), f[31:0])};
    endfunction

    // receiver: random stall, check each accepted word
    always @(negedge i_clk) begin
        if (i_rst_n) i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time,
                         o_packed_word);
                errors++;
            end else begin
                if (o_packed_word !== expected_words[0]) begin
                    $display("%0t: packed_word mismatch, expected %h, actual %h",
                             $time, expected_words[0], o_packed_word);
                    errors++;
                end
                void'(expected_words.pop_front());
            end
        end
    end

    // drive one item, holding it until accepted; valid stays up for the next call
    task automatic send_item(logic [2:0] c, logic s, logic signed [15:0] e, logic [63:0] f);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value_class <= c;
        i_sign_bit <= s;
        i_unbiased_exponent <= e;
        i_mantissa_bits <= f;
        expected_words.push_back(predict_word(c, s, e, f));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // wait for drain, then write precision
    task automatic set_precision(logic p);
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= p;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        dbl_mode = p;
    endtask

    task automatic test_directed();
        logic [63:0] h;
        h = dbl_mode ? 64'h1000000000000000 : 64'h40000000;
        send_item(frp_pkg::CLS_QNAN, 1'b0, 16'sd0, 64'd0);
        send_item(frp_pkg::CLS_SNAN, 1'b1, 16'sd0, '1);
        send_item(frp_pkg::CLS_ZERO, 1'b1, 16'sd5, '1);
        send_item(frp_pkg::CLS_INF, 1'b0, -16'sd3, 64'd7);
        send_item(CLS_NUM, 1'b0, 16'sd0, 64'd0);            // zero fraction
        send_item(CLS_NUM, 1'b1, 16'sd0, h);
        send_item(CLS_NUM, 1'b0, 16'sd0, h | 64'h80);       // tie cases
        send_item(CLS_NUM, 1'b0, 16'sd0, h | 64'h180);
        send_item(CLS_NUM, 1'b0, 16'sd0, h | 64'h40);
        send_item(CLS_NUM, 1'b0, 16'sd0, h | 64'hc0);
        send_item(CLS_NUM, 1'b0, 16'sd0, (h << 1) - 1);     // carry out
        send_item(CLS_NUM, 1'b0, 16'sd127, (h << 1) - 1);
        send_item(CLS_NUM, 1'b0, 16'sd1023, (h << 1) - 1);
        send_item(CLS_NUM, 1'b1, 16'sd128, h);              // overflow
        send_item(CLS_NUM, 1'b0, 16'sd1024, h);
        send_item(CLS_NUM, 1'b0, 16'sh7fff, h);
        send_item(CLS_NUM, 1'b0, -16'sd127, h);             // subnormal
        send_item(CLS_NUM, 1'b0, -16'sd1023, h);
        send_item(CLS_NUM, 1'b0, -16'sd127, (h << 1) - 1);  // rounds to min normal
        send_item(CLS_NUM, 1'b0, -16'sd1023, (h << 1) - 1);
        send_item(CLS_NUM, 1'b1, 16'sh8000, 64'd1);         // sticky only
        send_item(3'd5, 1'b0, 16'sd1, '1);
        send_item(3'd7, 1'b1, -16'sd1, h);
    endtask

    task automatic test_random(int n);
        logic [2:0]  c;
        logic [15:0] e;
        logic [63:0] f;
        int          r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            c = (r < 70) ? CLS_NUM : 3'($urandom_range(7));
            f = {$urandom, $urandom};
            case ($urandom_range(3))
                0: e = 16'($urandom);
                1: e = 16'($signed($urandom_range(300)) - 150);
                default: e = 16'($signed($urandom_range(2200)) - 1100);
            endcase
            if ($urandom_range(3) == 0) f = f >> $urandom_range(63);
            send_item(c, 1'($urandom), e, f);
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_idle_pct = 9;
        recv_idle_pct = 51;
        test_directed();
        test_random(130);
        set_precision(1'b0);
        test_directed();
        test_random(130);
        send_idle_pct = 51;
        recv_idle_pct = 9;
        test_random(130);
        set_precision(1'b1);
        test_random(130);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(120);
        set_precision(1'b0);
        test_random(120);
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
